/* src/nsfc_pkg.sv */
// Shared types, constants and helper functions of the NMEA sentence framer and checker.
package nsfc_pkg;

  // Field widths of the input and result items
  localparam int unsigned ByteW       = 8;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned TypeW       = 2;
  localparam int unsigned FieldCountW = 5;
  localparam int unsigned IdentLenW   = 3;
  localparam int unsigned IdentDepth  = 5;

  // Default field limit and the largest value the fields_total port can show
  localparam int unsigned MaxFieldsDef = 24;
  localparam int unsigned FieldCntMax  = (1 << FieldCountW) - 1;

  // Identifier length handling: five characters kept, length saturates one above
  localparam logic [IdentLenW-1:0] IdentLenFull = IdentLenW'(IdentDepth);
  localparam logic [IdentLenW-1:0] IdentLenSat  = IdentLenW'(IdentDepth + 1);

  // Per-type field-count rules
  localparam int unsigned GgaRmcMinFields = 10;
  localparam int unsigned GsaMinFields    = 18;
  localparam int unsigned GsvMinFields    = 4;
  localparam int unsigned GsvMaxGroups    = 4;

  // Framing characters
  localparam logic [ByteW-1:0] ChDollar = 8'h24;
  localparam logic [ByteW-1:0] ChStar   = 8'h2A;
  localparam logic [ByteW-1:0] ChComma  = 8'h2C;

  // Sentence formatters, last three identifier characters
  localparam logic [3*ByteW-1:0] IdGga = "GGA";
  localparam logic [3*ByteW-1:0] IdGsa = "GSA";
  localparam logic [3*ByteW-1:0] IdGsv = "GSV";
  localparam logic [3*ByteW-1:0] IdRmc = "RMC";

  typedef enum logic [2:0] {
    PH_START,
    PH_PAYLOAD,
    PH_HEX_HIGH,
    PH_HEX_LOW,
    PH_TAIL,
    PH_SKIP
  } nsfc_phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK,
    ST_FRAMING,
    ST_FIELDS,
    ST_IGNORED
  } nsfc_status_e;

  typedef enum logic [TypeW-1:0] {
    MT_GGA,
    MT_GSA,
    MT_GSV,
    MT_RMC
  } nsfc_type_e;

  typedef struct packed {
    nsfc_status_e           status;
    nsfc_type_e             message_type;
    logic [FieldCountW-1:0] fields_total;
    logic [ByteW-1:0]       computed_checksum;
    logic [ByteW-1:0]       talker_first;
    logic [ByteW-1:0]       talker_second;
  } nsfc_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } nsfc_hex_t;

  // ASCII hex digit decode, either case
  function automatic nsfc_hex_t hex_decode(input logic [ByteW-1:0] c);
    nsfc_hex_t h;
    h.ok  = 1'b0;
    h.val = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h57);
    end
    return h;
  endfunction

endpackage

/* src/nsfc_if.sv */
// Valid/ready channel interfaces for sentence bytes and for check results.
interface nsfc_in_if;
  logic                       valid;
  logic                       ready;
  logic [nsfc_pkg::ByteW-1:0] byte_in;
  logic                       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface nsfc_out_if;
  logic                             valid;
  logic                             ready;
  logic [nsfc_pkg::StatusW-1:0]     status;
  logic [nsfc_pkg::TypeW-1:0]       message_type;
  logic [nsfc_pkg::FieldCountW-1:0] fields_total;
  logic [nsfc_pkg::ByteW-1:0]       computed_checksum;
  logic [nsfc_pkg::ByteW-1:0]       talker_first;
  logic [nsfc_pkg::ByteW-1:0]       talker_second;

  modport source (output valid, output status, output message_type, output fields_total,
                  output computed_checksum, output talker_first, output talker_second,
                  input ready);
  modport sink   (input valid, input status, input message_type, input fields_total,
                  input computed_checksum, input talker_first, input talker_second,
                  output ready);
endinterface

/* src/nsfc_core.sv */
// Per-byte sentence state machine, checksum, field counter and final classification.
module nsfc_core #(
  parameter int unsigned MaxFields = nsfc_pkg::MaxFieldsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_valid_i,
  input  logic [nsfc_pkg::ByteW-1:0] byte_i,
  input  logic                       last_i,
  output logic                       res_valid_o,
  output nsfc_pkg::nsfc_result_t     res_o
);
  import nsfc_pkg::*;

  // Field counter holds up to MaxFields + 1
  localparam int unsigned FieldW = $clog2(MaxFields + 2);

  nsfc_phase_e            phase_q, phase_s;
  logic [ByteW-1:0]       xor_q, xor_s;
  logic [FieldW-1:0]      fields_q, fields_s;
  logic [IdentLenW-1:0]   len_q, len_s;
  logic [ByteW-1:0]       ident_q [IdentDepth];
  logic [ByteW-1:0]       ident_s [IdentDepth];
  logic [3:0]             nib_q, nib_s;
  logic                   ferr_q, ferr_s;
  nsfc_hex_t              hex;
  logic [3*ByteW-1:0]     fmt;
  logic                   ident_five;
  logic [FieldW-1:0]      gsv_extra;

  assign hex = hex_decode(byte_i);

  // Next phase for the incoming byte
  always_comb begin
    phase_s = phase_q;
    case (phase_q)
      PH_START:    phase_s = (byte_i == ChDollar) ? PH_PAYLOAD : PH_SKIP;
      PH_PAYLOAD:  if (byte_i == ChStar) phase_s = PH_HEX_HIGH;
      PH_HEX_HIGH: phase_s = PH_HEX_LOW;
      PH_HEX_LOW:  phase_s = PH_TAIL;
      PH_TAIL:     phase_s = PH_TAIL;
      PH_SKIP:     phase_s = PH_SKIP;
      default:     phase_s = phase_q;
    endcase
  end

  // Datapath update for the incoming byte
  always_comb begin
    xor_s    = xor_q;
    fields_s = fields_q;
    len_s    = len_q;
    ident_s  = ident_q;
    nib_s    = nib_q;
    ferr_s   = ferr_q;
    case (phase_q)
      PH_START: begin
        if (byte_i == ChDollar) fields_s = FieldW'(1);
        else                    ferr_s   = 1'b1;
      end
      PH_PAYLOAD: begin
        if (byte_i != ChStar) begin
          xor_s = xor_q ^ byte_i;
          if (byte_i == ChComma) begin
            if (32'(fields_q) <= 32'(MaxFields)) fields_s = fields_q + FieldW'(1);
          end else if (fields_q == FieldW'(1)) begin
            // identifier characters, first five kept
            for (int i = 0; i < IdentDepth; i++) begin
              if (len_q == IdentLenW'(i)) ident_s[i] = byte_i;
            end
            if (len_q < IdentLenSat) len_s = len_q + IdentLenW'(1);
          end
        end
      end
      PH_HEX_HIGH: begin
        if (!hex.ok) ferr_s = 1'b1;
        else         nib_s  = hex.val;
      end
      PH_HEX_LOW: begin
        if (!hex.ok || {nib_q, hex.val} != xor_q) ferr_s = 1'b1;
      end
      PH_TAIL:  ferr_s = 1'b1;
      default:  ferr_s = ferr_q;
    endcase
  end

  // Classification of the finished sentence
  assign fmt        = {ident_s[2], ident_s[3], ident_s[4]};
  assign ident_five = (len_s == IdentLenFull);
  assign gsv_extra  = fields_s - FieldW'(GsvMinFields);

  always_comb begin
    res_o.message_type      = MT_GGA;
    res_o.status            = ST_OK;
    res_o.computed_checksum = xor_s;
    res_o.talker_first      = ident_s[0];
    res_o.talker_second     = ident_s[1];
    res_o.fields_total      = (32'(fields_s) > 32'(FieldCntMax)) ?
                              FieldCountW'(FieldCntMax) : fields_s[FieldCountW-1:0];

    if (ident_five && fmt == IdGsa)      res_o.message_type = MT_GSA;
    else if (ident_five && fmt == IdGsv) res_o.message_type = MT_GSV;
    else if (ident_five && fmt == IdRmc) res_o.message_type = MT_RMC;

    if (ferr_s || phase_s != PH_TAIL) begin
      res_o.status = ST_FRAMING;
    end else if (32'(fields_s) > 32'(MaxFields)) begin
      res_o.status = ST_FIELDS;
    end else if (!ident_five ||
                 !(fmt == IdGga || fmt == IdGsa || fmt == IdGsv || fmt == IdRmc)) begin
      res_o.status = ST_IGNORED;
    end else if (fmt == IdGga || fmt == IdRmc) begin
      if (32'(fields_s) < 32'(GgaRmcMinFields)) res_o.status = ST_FIELDS;
    end else if (fmt == IdGsa) begin
      if (32'(fields_s) < 32'(GsaMinFields)) res_o.status = ST_FIELDS;
    end else begin
      // GSV: four header fields then groups of four, one spare field allowed
      if (32'(fields_s) < 32'(GsvMinFields) || gsv_extra[1] ||
          32'(gsv_extra >> 2) > 32'(GsvMaxGroups)) res_o.status = ST_FIELDS;
    end
  end

  assign res_valid_o = step_valid_i && last_i;

  // State registers, cleared again after each final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      xor_q    <= '0;
      fields_q <= '0;
      len_q    <= '0;
      nib_q    <= '0;
      ferr_q   <= 1'b0;
      for (int i = 0; i < IdentDepth; i++) ident_q[i] <= '0;
    end else if (step_valid_i) begin
      if (last_i) begin
        phase_q  <= PH_START;
        xor_q    <= '0;
        fields_q <= '0;
        len_q    <= '0;
        nib_q    <= '0;
        ferr_q   <= 1'b0;
        for (int i = 0; i < IdentDepth; i++) ident_q[i] <= '0;
      end else begin
        phase_q  <= phase_s;
        xor_q    <= xor_s;
        fields_q <= fields_s;
        len_q    <= len_s;
        nib_q    <= nib_s;
        ferr_q   <= ferr_s;
        ident_q  <= ident_s;
      end
    end
  end

endmodule

/* src/nmea_sentence_framer_checker.sv */
// Top level of the NMEA sentence framer and checker: byte step plus result buffering.
// A result is registered on out_o, via the skid entry if an earlier result still waits.
// One byte per cycle while a skid slot is free; the state step is a single registered pass.
// A result register with one skid entry lets bytes keep flowing while a result waits.
// Reset (rst_ni low, asynchronous) returns to awaiting '$' and empties both result entries.
module nmea_sentence_framer_checker #(
  parameter int unsigned MaxFields = nsfc_pkg::MaxFieldsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nsfc_in_if.sink   in_i,
  nsfc_out_if.source out_o
);
  import nsfc_pkg::*;

  logic         accept;
  logic         res_valid;
  nsfc_result_t res;
  logic         out_valid_q, skid_valid_q;
  nsfc_result_t out_q, skid_q;
  logic         out_pop;

  assign in_i.ready = !skid_valid_q;
  assign accept     = in_i.valid && in_i.ready;
  assign out_pop    = out_valid_q && out_o.ready;

  nsfc_core #(
    .MaxFields(MaxFields)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_valid_i(accept),
    .byte_i      (in_i.byte_in),
    .last_i      (in_i.last_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register and skid entry control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_pop || !out_valid_q) begin
        out_valid_q  <= skid_valid_q || res_valid;
        skid_valid_q <= 1'b0;
      end else if (res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Result payloads
  always_ff @(posedge clk_i) begin
    if (out_pop || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.status            = out_q.status;
  assign out_o.message_type      = out_q.message_type;
  assign out_o.fields_total      = out_q.fields_total;
  assign out_o.computed_checksum = out_q.computed_checksum;
  assign out_o.talker_first      = out_q.talker_first;
  assign out_o.talker_second     = out_q.talker_second;

endmodule

/* src/nsfc_checker.sv */
// Port-level assertions for the NMEA sentence framer and checker, bound to the top level.
module nsfc_checker #(
  parameter int unsigned MaxFields = nsfc_pkg::MaxFieldsDef
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             in_last_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [nsfc_pkg::StatusW-1:0]     status_i,
  input logic [nsfc_pkg::TypeW-1:0]       message_type_i,
  input logic [nsfc_pkg::FieldCountW-1:0] fields_total_i
);
  import nsfc_pkg::*;

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before it was taken");

  // Input back-pressure only while a result is pending
  a_ready_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no pending result");

  // A taken final byte shows a result in the next cycle
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> out_valid_i)
    else $error("final byte gave no result");

  // Field count never passes the saturation point
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(fields_total_i) <= 32'(MaxFields + 1))
    else $error("field count above saturation");

  // An accepted GSA sentence carries at least its minimum fields
  a_gsa_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_OK && message_type_i == MT_GSA |->
      32'(fields_total_i) >= 32'(GsaMinFields))
    else $error("GSA accepted with too few fields");

endmodule

bind nmea_sentence_framer_checker nsfc_checker #(
  .MaxFields(MaxFields)
) u_nsfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_last_i     (in_i.last_byte),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .message_type_i(out_o.message_type),
  .fields_total_i(out_o.fields_total)
);

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the NMEA sentence framer and checker.
module tb;
  import nsfc_pkg::*;

  localparam int unsigned FieldLimit  = MaxFieldsDef;
  localparam int unsigned GsvGroup    = 4;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned TargetBytes = 600;
  localparam int unsigned TargetLines = 6;

  // Ways a generated sentence can be broken
  typedef enum int {
    FLT_NONE,
    FLT_BAD_SUM,
    FLT_BAD_HEX_HI,
    FLT_BAD_HEX_LO,
    FLT_NO_STAR,
    FLT_CUT_STAR,
    FLT_CUT_HEX,
    FLT_TAIL,
    FLT_NO_DOLLAR
  } fault_e;

  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             last;
  } char_item_t;

  logic clk_i;
  logic rst_ni;

  nsfc_in_if  in_if ();
  nsfc_out_if out_if ();

  nmea_sentence_framer_checker dut (
    .clk_i,
    .rst_ni,
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Stimulus store and the sentence under construction
  char_item_t       pending[$];
  logic [ByteW-1:0] line[$];
  int unsigned      lines_built;
  int unsigned      fill_max = 0;

  // Expected verdicts, oldest first
  nsfc_result_t verdicts_due[$];

  // Shadow of the sentence tracker
  nsfc_phase_e      ph;
  logic [ByteW-1:0] sum_acc;
  int unsigned      nfields;
  int unsigned      id_len;
  logic [ByteW-1:0] id_ch[IdentDepth];
  logic [3:0]       hi_nib;
  logic             bad_frame;

  logic        in_taken = 1'b0;
  int unsigned results_seen = 0;
  int unsigned err_count = 0;
  int unsigned idle_cycles = 0;

  // Driver and receiver pacing
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic [15:0] stall_mask = '1;
  logic [3:0]  pat_pos = '0;

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- prediction

  function automatic int digit_value(logic [ByteW-1:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'(8'h30);
    if (c >= "A" && c <= "F") return int'(c) - int'(8'h41) + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'(8'h61) + 10;
    return -1;
  endfunction

  task automatic clear_frame();
    ph        = PH_START;
    sum_acc   = '0;
    nfields   = 0;
    id_len    = 0;
    hi_nib    = '0;
    bad_frame = 1'b0;
    foreach (id_ch[i]) id_ch[i] = '0;
  endtask

  // Advance the shadow by one character; on the final one, queue the verdict
  task automatic frame_step(logic [ByteW-1:0] b, logic last);
    int           d;
    nsfc_result_t v;
    logic         known;
    logic [23:0]  fmt;
    int unsigned  rest;
    case (ph)
      PH_START: begin
        if (b == ChDollar) begin
          ph      = PH_PAYLOAD;
          nfields = 1;
        end else begin
          bad_frame = 1'b1;
          ph        = PH_SKIP;
        end
      end
      PH_PAYLOAD: begin
        if (b == ChStar) begin
          ph = PH_HEX_HIGH;
        end else begin
          sum_acc ^= b;
          if (b == ChComma) begin
            if (nfields <= FieldLimit) nfields++;
          end else if (nfields == 1) begin
            if (id_len < IdentDepth) id_ch[id_len] = b;
            if (id_len <= IdentDepth) id_len++;
          end
        end
      end
      PH_HEX_HIGH: begin
        d = digit_value(b);
        if (d < 0) bad_frame = 1'b1;
        else hi_nib = 4'(d);
        ph = PH_HEX_LOW;
      end
      PH_HEX_LOW: begin
        d = digit_value(b);
        if (d < 0 || {hi_nib, 4'(d)} != sum_acc) bad_frame = 1'b1;
        ph = PH_TAIL;
      end
      PH_TAIL: bad_frame = 1'b1;
      default: ;
    endcase

    if (last) begin
      fmt            = {id_ch[2], id_ch[3], id_ch[4]};
      known          = (id_len == IdentDepth);
      v.message_type = MT_GGA;
      if (known) begin
        if (fmt == IdGga) v.message_type = MT_GGA;
        else if (fmt == IdGsa) v.message_type = MT_GSA;
        else if (fmt == IdGsv) v.message_type = MT_GSV;
        else if (fmt == IdRmc) v.message_type = MT_RMC;
        else known = 1'b0;
      end

      if (bad_frame || ph != PH_TAIL) begin
        v.status = ST_FRAMING;
      end else if (nfields > FieldLimit) begin
        v.status = ST_FIELDS;
      end else if (!known) begin
        v.status = ST_IGNORED;
      end else begin
        case (v.message_type)
          MT_GGA, MT_RMC: v.status = (nfields < GgaRmcMinFields) ? ST_FIELDS : ST_OK;
          MT_GSA:         v.status = (nfields < GsaMinFields) ? ST_FIELDS : ST_OK;
          default: begin
            // satellites in view: four header fields, then whole groups of four,
            // optionally with one trailing field
            rest = nfields - GsvMinFields;
            v.status = (nfields < GsvMinFields || rest % GsvGroup > 1 ||
                        rest / GsvGroup > GsvMaxGroups) ? ST_FIELDS : ST_OK;
          end
        endcase
      end

      v.fields_total      = FieldCountW'(nfields > FieldCntMax ? FieldCntMax : nfields);
      v.computed_checksum = sum_acc;
      v.talker_first      = id_ch[0];
      v.talker_second     = id_ch[1];
      verdicts_due.push_back(v);
      clear_frame();
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  // Payload character: never a star or comma, now and then a zero or high byte
  function automatic logic [ByteW-1:0] field_char();
    logic [ByteW-1:0] c;
    do begin
      case ($urandom_range(0, 19))
        0:       c = 8'h00;
        1:       c = 8'($urandom_range(128, 255));
        default: c = 8'($urandom_range(32, 126));
      endcase
    end while (c == ChStar || c == ChComma);
    return c;
  endfunction

  function automatic logic [ByteW-1:0] hex_char(logic [3:0] n, logic upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [ByteW-1:0] non_hex_char();
    logic [ByteW-1:0] c;
    do c = 8'($urandom); while (digit_value(c) >= 0);
    return c;
  endfunction

  // Move the built sentence into the pending items, flagging its final character
  task automatic commit_line();
    foreach (line[i]) pending.push_back(char_item_t'{line[i], i == line.size() - 1});
    line.delete();
    lines_built++;
  endtask

  task automatic framed(logic [39:0] ident, int unsigned id_chars, int unsigned nf,
                        fault_e fault);
    logic [ByteW-1:0] sum;
    logic             upper;
    sum   = '0;
    upper = 1'($urandom_range(0, 1));
    line.push_back(fault == FLT_NO_DOLLAR ? ChDollar ^ 8'($urandom_range(1, 255)) : ChDollar);
    for (int i = 0; i < id_chars; i++)
      line.push_back(i < IdentDepth ? ident[39 - 8 * i -: 8] : field_char());
    for (int f = 1; f < nf; f++) begin
      line.push_back(ChComma);
      repeat ($urandom_range(0, fill_max)) line.push_back(field_char());
    end
    for (int i = 1; i < line.size(); i++) sum ^= line[i];

    case (fault)
      FLT_NO_STAR: ;
      FLT_CUT_STAR: line.push_back(ChStar);
      FLT_CUT_HEX: begin
        line.push_back(ChStar);
        line.push_back(hex_char(sum[7:4], upper));
      end
      default: begin
        if (fault == FLT_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
        line.push_back(ChStar);
        line.push_back(fault == FLT_BAD_HEX_HI ? non_hex_char() : hex_char(sum[7:4], upper));
        line.push_back(fault == FLT_BAD_HEX_LO ? non_hex_char() : hex_char(sum[3:0], upper));
        if (fault == FLT_TAIL) repeat ($urandom_range(1, 3)) line.push_back(8'($urandom));
      end
    endcase
    commit_line();
  endtask

  task automatic noise_line();
    repeat ($urandom_range(1, 6)) line.push_back(8'($urandom));
    commit_line();
  endtask

  // Mostly well-formed sentences near the field-count boundaries
  task automatic random_sentence();
    logic [23:0] fmt;
    logic [15:0] talker;
    int unsigned kind;
    int unsigned len;
    int unsigned nf;
    fault_e      fault;
    kind   = $urandom_range(0, 9);
    talker = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90))};
    case (kind)
      0, 1: begin fmt = IdGga; nf = $urandom_range(7, 13); end
      2, 3: begin fmt = IdGsa; nf = $urandom_range(15, 20); end
      4, 5: begin fmt = IdGsv; nf = $urandom_range(1, 26); end
      6, 7: begin fmt = IdRmc; nf = $urandom_range(7, 13); end
      default: begin
        fmt = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
               8'($urandom_range(65, 90))};
        nf  = $urandom_range(1, 10);
      end
    endcase
    if ($urandom_range(0, 9) == 0) nf = $urandom_range(22, 28);
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : IdentDepth;
    fault = ($urandom_range(0, 99) < 75) ? FLT_NONE
                                         : fault_e'($urandom_range(FLT_BAD_SUM, FLT_NO_DOLLAR));
    framed({talker, fmt}, len, nf, fault);
  endtask

  // ---------------------------------------------------------------- sender

  // Bursts of random length separated by random gaps; an offered item is held
  always @(negedge clk_i) begin
    logic offer;
    if (rst_ni) begin
      if (in_taken) void'(pending.pop_front());
      offer = in_if.valid && !in_taken;
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending.size() != 0) begin
          offer = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end
      end
      if (offer) begin
        in_if.byte_in   <= pending[0].ch;
        in_if.last_byte <= pending[0].last;
      end
      in_if.valid <= offer;
    end
  end

  // ---------------------------------------------------------------- receiver

  // Random stall pattern, with one long hold-off to back the block up
  always @(negedge clk_i) begin
    logic rdy;
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && results_seen >= 12) begin
        hold_done = 1'b1;
        hold_left = LongHold;
        rdy       = 1'b0;
      end else begin
        if (pat_pos == 0) stall_mask = ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom | $urandom);
        rdy = stall_mask[pat_pos];
        pat_pos++;
      end
      out_if.ready <= rdy;
    end
  end

  // ---------------------------------------------------------------- monitor

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    nsfc_result_t want;
    if (rst_ni) begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) frame_step(in_if.byte_in, in_if.last_byte);
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (verdicts_due.size() == 0) begin
          $error("result item arrived with none expected");
          err_count++;
        end else begin
          want = verdicts_due.pop_front();
          check_field("status", int'(want.status), int'(out_if.status));
          check_field("message_type", int'(want.message_type), int'(out_if.message_type));
          check_field("fields_total", int'(want.fields_total), int'(out_if.fields_total));
          check_field("computed_checksum", int'(want.computed_checksum),
                      int'(out_if.computed_checksum));
          check_field("talker_first", int'(want.talker_first), int'(out_if.talker_first));
          check_field("talker_second", int'(want.talker_second), int'(out_if.talker_second));
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.byte_in   = '0;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    lines_built     = 0;
    clear_frame();

    // Directed, with empty fields: every type, field-count edges and each way
    // to break a sentence
    fill_max = 0;
    framed("GPGGA", 5, 10, FLT_NONE);
    framed("GNGSA", 5, 18, FLT_NONE);
    framed("GPGSV", 5, 4, FLT_NONE);
    framed("GPGSV", 5, 9, FLT_NONE);
    framed("GLGSV", 5, 21, FLT_NONE);
    framed("GPGSV", 5, 7, FLT_NONE);   // group remainder of three
    framed("GPGSV", 5, 24, FLT_NONE);  // five groups
    framed("GPGSV", 5, 3, FLT_NONE);   // short header
    framed("GPRMC", 5, 10, FLT_NONE);
    framed("GPRMC", 5, 9, FLT_NONE);
    framed("GPGSA", 5, 17, FLT_NONE);
    framed("GPGGA", 5, 25, FLT_NONE);  // one field over the limit
    framed("GPZDA", 5, 27, FLT_NONE);  // over the limit, unknown type
    framed("GPZDA", 5, 6, FLT_NONE);
    framed("GPGGA", 4, 10, FLT_NONE);  // short identifier
    framed("GPGGA", 7, 10, FLT_NONE);  // long identifier
    framed({8'h00, 8'hFF, "GGA"}, 5, 10, FLT_NONE);
    framed("GPGGA", 5, 10, FLT_NO_DOLLAR);
    framed("GPGGA", 5, 10, FLT_BAD_SUM);
    framed("GPGGA", 5, 10, FLT_BAD_HEX_HI);
    framed("GPRMC", 5, 10, FLT_BAD_HEX_LO);
    framed("GPGGA", 5, 10, FLT_CUT_STAR);
    framed("GPGSA", 5, 18, FLT_CUT_HEX);
    framed("GPGGA", 5, 10, FLT_TAIL);
    framed("GPGGA", 0, 1, FLT_NO_STAR);  // lone dollar
    line.push_back(8'h00);
    commit_line();
    line.push_back(8'hFF);
    commit_line();

    // Random sentences with short field contents and a little noise
    fill_max    = 1;
    lines_built = 0;
    while (pending.size() < TargetBytes || lines_built < TargetLines) begin
      if ($urandom_range(0, 9) == 0) noise_line();
      else random_sentence();
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    while (pending.size() != 0 || in_if.valid || verdicts_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* nmea_sentence_framer_checker.f */
src/nsfc_pkg.sv
src/nsfc_if.sv
src/nsfc_core.sv
src/nmea_sentence_framer_checker.sv
src/nsfc_checker.sv
bench/tb.sv
